@@ design/smd_pkg.sv @@
// ---------------------------------------------------------------------------
// Sliding median package
// Shared constants, the sequencer state type and the cell control group.
// ---------------------------------------------------------------------------
package smd_pkg;

   localparam int LEN_BITS           = 9;
   localparam int WINDOW_MAX_DEF     = 256;
   localparam int SAMPLE_BITS_DEF    = 20;
   localparam int POSITION_BITS_DEF  = 20;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REMOVE,
      ST_INSERT,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic ins;
      logic rem;
   } cell_ctl_type;

endpackage

@@ design/smd_if.sv @@
// ---------------------------------------------------------------------------
// Sliding median channels
// Valid/ready channels for samples, results and the window length register.
// ---------------------------------------------------------------------------
interface smd_req_if #(parameter int SAMPLE_BITS = 20);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   start_req;
   modport source (output valid, sample, start_req, input ready);
   modport sink (input valid, sample, start_req, output ready);
endinterface

interface smd_rsp_if #(
   parameter int SAMPLE_BITS   = 20,
   parameter int COST_BITS     = 29,
   parameter int POSITION_BITS = 20
);
   logic                     valid;
   logic                     ready;
   logic [SAMPLE_BITS-1:0]   median;
   logic [COST_BITS-1:0]     window_cost;
   logic                     window_full;
   logic                     best_valid;
   logic [COST_BITS-1:0]     best_cost;
   logic [POSITION_BITS-1:0] best_end;
   logic [SAMPLE_BITS-1:0]   best_median;
   modport source (output valid, median, window_cost, window_full, best_valid, best_cost,
                   best_end, best_median, input ready);
   modport sink (input valid, median, window_cost, window_full, best_valid, best_cost,
                 best_end, best_median, output ready);
endinterface

interface smd_csr_if #(parameter int LEN_BITS = 9);
   logic                valid;
   logic                ready;
   logic [LEN_BITS-1:0] window_length;
   modport source (output valid, window_length, input ready);
   modport sink (input valid, window_length, output ready);
endinterface

@@ design/sliding_median_min_deviation.sv @@
// ---------------------------------------------------------------------------
// Sliding window median with minimum deviation
// Running lower median and absolute deviation cost over a sliding window.
// ---------------------------------------------------------------------------
// Samples enter on the req_ch channel, one item each, and every item yields
// one result item on rsp_ch. The csr_ch channel writes the window length and
// is always ready; the user is to write it only while the block is idle, and
// the block itself does not enforce it. The window is held sorted in a row
// of WINDOW_MAX cells. The oldest sample is removed when the window is full
// and the new one inserted, the oldest value coming from an arrival memory.
// A sweep then carries the lower and upper sums and the median down the row,
// one cell per cycle. For each item the sequencer checks the fill, removes
// and checks again while the fill is at or over the length, then inserts,
// sweeps and finishes. That is one removal per item once the window is full,
// more after the length is reduced; one item is in work at a time.
// The result register lets a new item be taken while a result waits; a
// stalled receiver holds the finished item in the sequencer until taken.
// Reset clears the window, the position and the best result and sets the
// length to one; a set start_req flag clears the same but the length.
// ---------------------------------------------------------------------------
module sliding_median_min_deviation import smd_pkg::*; #(
   parameter int WINDOW_MAX    = WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int COST_BITS     = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1
) (
   input logic       clock,
   input logic       reset,
   smd_req_if.sink   req_ch,
   smd_rsp_if.source rsp_ch,
   smd_csr_if.sink   csr_ch
);

   localparam int AW       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int FW       = $clog2(WINDOW_MAX + 1);
   localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_MAX);

   state_type state_ff, state_in;
   cell_ctl_type ctl;

   logic [LEN_BITS-1:0]      len_ff;
   logic [FW-1:0]            eff_len, fill_ff, scan_ff;
   logic [AW-1:0]            head_ff, tail, mid_ff;
   logic                     even_ff;
   logic [FW:0]              tail_sum;
   logic [SAMPLE_BITS-1:0]   sample_ff, ring_q_ff, key;
   logic [SAMPLE_BITS-1:0]   ring_mem [WINDOW_MAX];
   logic [POSITION_BITS-1:0] pos_ff;
   logic                     best_seen_ff;
   logic [COST_BITS-1:0]     best_cost_ff, cost;
   logic [POSITION_BITS-1:0] best_end_ff;
   logic [SAMPLE_BITS-1:0]   best_med_ff;
   logic                     rsp_valid_ff, full, take, accept, out_free;

   logic [SAMPLE_BITS-1:0] c_val [WINDOW_MAX];
   logic                   c_vld [WINDOW_MAX];
   logic                   c_gt  [WINDOW_MAX];
   logic [SUM_BITS-1:0]    c_lo  [WINDOW_MAX];
   logic [SUM_BITS-1:0]    c_hi  [WINDOW_MAX];
   logic [SAMPLE_BITS-1:0] c_med [WINDOW_MAX];

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      if (len_ff == '0) begin
         eff_len = FW'(1);
      end else if (32'(len_ff) > 32'(WINDOW_MAX)) begin
         eff_len = FW'(WINDOW_MAX);
      end else begin
         eff_len = FW'(len_ff);
      end
   end

   assign tail_sum = (FW + 1)'(head_ff) + (FW + 1)'(fill_ff);
   assign tail = (tail_sum >= (FW + 1)'(WINDOW_MAX)) ?
                 AW'(tail_sum - (FW + 1)'(WINDOW_MAX)) : AW'(tail_sum);
   assign key  = (state_ff == ST_REMOVE) ? ring_q_ff : sample_ff;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      ctl.clear = accept && req_ch.start_req;
      take      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = (fill_ff >= eff_len) ? ST_REMOVE : ST_INSERT;
         end
         ST_REMOVE: begin
            ctl.rem  = 1'b1;
            state_in = ST_CHECK;
         end
         ST_INSERT: begin
            ctl.ins  = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_ff == FW'(WINDOW_MAX - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               take     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ring_q_ff <= ring_mem[head_ff];
      if (state_ff == ST_INSERT) begin
         ring_mem[tail] <= sample_ff;
      end
   end

   assign cost = COST_BITS'(c_hi[WINDOW_MAX-1]) - COST_BITS'(c_lo[WINDOW_MAX-1])
               - (even_ff ? COST_BITS'(c_med[WINDOW_MAX-1]) : '0);
   assign full = (fill_ff == eff_len);

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_ch.sample;
      end
      if (state_ff == ST_INSERT) begin
         mid_ff  <= AW'(fill_ff >> 1);
         even_ff <= fill_ff[0];
      end
      scan_ff <= (state_ff == ST_SCAN) ? scan_ff + FW'(1) : '0;
      if (take) begin
         rsp_ch.median      <= c_med[WINDOW_MAX-1];
         rsp_ch.window_cost <= cost;
         rsp_ch.window_full <= full;
         if (full && (!best_seen_ff || cost < best_cost_ff)) begin
            rsp_ch.best_valid  <= 1'b1;
            rsp_ch.best_cost   <= cost;
            rsp_ch.best_end    <= pos_ff;
            rsp_ch.best_median <= c_med[WINDOW_MAX-1];
         end else begin
            rsp_ch.best_valid  <= best_seen_ff;
            rsp_ch.best_cost   <= best_cost_ff;
            rsp_ch.best_end    <= best_end_ff;
            rsp_ch.best_median <= best_med_ff;
         end
      end
      if (reset) begin
         len_ff       <= LEN_BITS'(1);
         fill_ff      <= '0;
         head_ff      <= '0;
         pos_ff       <= '0;
         best_seen_ff <= 1'b0;
         best_cost_ff <= '0;
         best_end_ff  <= '0;
         best_med_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            len_ff <= csr_ch.window_length;
         end
         if (ctl.clear) begin
            fill_ff      <= '0;
            head_ff      <= '0;
            pos_ff       <= '0;
            best_seen_ff <= 1'b0;
            best_cost_ff <= '0;
            best_end_ff  <= '0;
            best_med_ff  <= '0;
         end
         if (state_ff == ST_REMOVE) begin
            fill_ff <= fill_ff - FW'(1);
            head_ff <= (32'(head_ff) == WINDOW_MAX - 1) ? '0 : head_ff + AW'(1);
         end
         if (state_ff == ST_INSERT) begin
            fill_ff <= fill_ff + FW'(1);
         end
         if (take) begin
            if (full && (!best_seen_ff || cost < best_cost_ff)) begin
               best_seen_ff <= 1'b1;
               best_cost_ff <= cost;
               best_end_ff  <= pos_ff;
               best_med_ff  <= c_med[WINDOW_MAX-1];
            end
            if (pos_ff != '1) begin
               pos_ff <= pos_ff + POSITION_BITS'(1);
            end
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic [SAMPLE_BITS-1:0] lv, rv, mi;
      logic                   lvd, lg, rvd;
      logic [SUM_BITS-1:0]    li, hi;
      if (i == 0) begin : g_first
         assign lv  = '0;
         assign lvd = 1'b0;
         assign lg  = 1'b0;
         assign li  = '0;
         assign hi  = '0;
         assign mi  = '0;
      end else begin : g_mid
         assign lv  = c_val[i-1];
         assign lvd = c_vld[i-1];
         assign lg  = c_gt[i-1];
         assign li  = c_lo[i-1];
         assign hi  = c_hi[i-1];
         assign mi  = c_med[i-1];
      end
      if (i == WINDOW_MAX - 1) begin : g_last
         assign rv  = '0;
         assign rvd = 1'b0;
      end else begin : g_inner
         assign rv  = c_val[i+1];
         assign rvd = c_vld[i+1];
      end
      smd_cell #(
         .SAMPLE_BITS(SAMPLE_BITS),
         .SUM_BITS(SUM_BITS),
         .AW(AW),
         .IDX(i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .ctl(ctl),
         .key(key),
         .mid(mid_ff),
         .left_val(lv),
         .left_vld(lvd),
         .left_gt(lg),
         .right_val(rv),
         .right_vld(rvd),
         .val(c_val[i]),
         .vld(c_vld[i]),
         .gt(c_gt[i]),
         .lo_in(li),
         .hi_in(hi),
         .med_in(mi),
         .lo_out(c_lo[i]),
         .hi_out(c_hi[i]),
         .med_out(c_med[i])
      );
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= WINDOW_MAX)
      else $error("window fill exceeds its capacity");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.start_req |=> fill_ff == '0 && !best_seen_ff)
      else $error("start did not clear the window");

   a_result_issued: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished item was not presented");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INSERT |-> fill_ff < eff_len)
      else $error("insert without room in the window");

endmodule

@@ design/smd_cell.sv @@
// ---------------------------------------------------------------------------
// Sliding median cell
// One slot of the sorted window with its share of the running sums.
// ---------------------------------------------------------------------------
module smd_cell import smd_pkg::*; #(
   parameter int SAMPLE_BITS = 20,
   parameter int SUM_BITS    = 28,
   parameter int AW          = 8,
   parameter int IDX         = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cell_ctl_type           ctl,
   input  logic [SAMPLE_BITS-1:0] key,
   input  logic [AW-1:0]          mid,
   input  logic [SAMPLE_BITS-1:0] left_val,
   input  logic                   left_vld,
   input  logic                   left_gt,
   input  logic [SAMPLE_BITS-1:0] right_val,
   input  logic                   right_vld,
   output logic [SAMPLE_BITS-1:0] val,
   output logic                   vld,
   output logic                   gt,
   input  logic [SUM_BITS-1:0]    lo_in,
   input  logic [SUM_BITS-1:0]    hi_in,
   input  logic [SAMPLE_BITS-1:0] med_in,
   output logic [SUM_BITS-1:0]    lo_out,
   output logic [SUM_BITS-1:0]    hi_out,
   output logic [SAMPLE_BITS-1:0] med_out
);

   logic [SAMPLE_BITS-1:0] val_ff, val_in;
   logic                   vld_ff, vld_in;
   logic [SUM_BITS-1:0]    lo_ff, hi_ff, ext;
   logic [SAMPLE_BITS-1:0] med_ff;
   logic                   ge;

   assign gt  = !vld_ff || (val_ff > key);
   assign ge  = !vld_ff || (val_ff >= key);
   assign ext = SUM_BITS'(val_ff);

   always_comb begin
      val_in = val_ff;
      vld_in = vld_ff;
      if (ctl.clear) begin
         vld_in = 1'b0;
      end else if (ctl.ins && gt) begin
         if (left_gt) begin
            val_in = left_val;
            vld_in = left_vld;
         end else begin
            val_in = key;
            vld_in = 1'b1;
         end
      end else if (ctl.rem && ge) begin
         val_in = right_val;
         vld_in = right_vld;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      lo_ff  <= (vld_ff && (AW'(IDX) < mid)) ? lo_in + ext : lo_in;
      hi_ff  <= (vld_ff && (AW'(IDX) > mid)) ? hi_in + ext : hi_in;
      med_ff <= (AW'(IDX) == mid) ? val_ff : med_in;
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign val     = val_ff;
   assign vld     = vld_ff;
   assign lo_out  = lo_ff;
   assign hi_out  = hi_ff;
   assign med_out = med_ff;

endmodule
